FILE: hdl/bss_pkg.sv
`timescale 1ns / 1ps
// Package for the bar section sequencer: widths, register indexes, item types,
// divider request and response types and the sequencer state type. No dependencies.
package bss_pkg;

  localparam int MAX_SECTIONS   = 12;
  localparam int SLOTS_PER_WORD = 6;
  localparam int FRAC_BITS      = 8;
  localparam int SLOT_W         = 10;
  localparam int SPB_W          = 30;
  localparam int WORD_W         = 60;
  localparam int CFG_DATA_W     = 60;
  localparam int CFG_IDX_W      = 3;
  localparam int SAMP_W         = 16;
  localparam int DIV_W          = 31;
  localparam int DIV_CNT_W      = 5;
  localparam int SEC_W          = 4;
  localparam int BARS_W         = 7;
  localparam int BIC_W          = 6;
  localparam int KIND_W         = 3;
  localparam int TOTAL_W        = 32;
  localparam int FORM_W         = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_WORDS_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_WORDS_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE        = 3'd4;

  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SAMP_W-1:0] num_samples;
  } in_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]   section_index;
    logic [KIND_W-1:0]  section_kind;
    logic [BARS_W-1:0]  bars_in_section;
    logic [BIC_W-1:0]   bars_elapsed;
    logic [TOTAL_W-1:0] global_bars;
    logic               last_bar;
    logic               done_res;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SPB_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [SPB_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_SKIP,
    ST_FIN
  } state_t;

endpackage

FILE: hdl/bss_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bss_pkg for widths and the request and response types.
module bss_divider (
  input  logic              clk,
  input  logic              rst,
  input  bss_pkg::div_req_t req,
  output bss_pkg::div_rsp_t rsp
);
  import bss_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [SPB_W-1:0]     rmd;
  logic [SPB_W-1:0]     dsr;
  logic [DIV_W-1:0]     trial;
  logic [DIV_W-1:0]     diff;
  logic                 ge;

  assign trial = {rmd, quo[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rmd <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rmd <= ge ? diff[SPB_W-1:0] : trial[SPB_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rmd;

endmodule

FILE: hdl/bar_section_sequencer.sv
`timescale 1ns / 1ps
// Top level of the bar section sequencer: configuration registers, section table lookup
// and the sequencer. Depends on bss_pkg and bss_divider.
//
// An advance item first divides its accumulated samples by the samples per bar, then walks
// the bars one stretch per step inside each section, and divides again each time whole
// looped forms are skipped. Restart items, and items that change nothing, go straight to
// their result. After a result is loaded, the next item can be taken in the following cycle.
// The shared restoring divider makes 31 steps, both for the bar count and for the form
// skip. One item is worked on at a time. Its result waits in an output register, so the
// next item can be taken while that result is still pending.
module bar_section_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [bss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bss_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bss_pkg::out_item_t                out_data
);
  import bss_pkg::*;

  logic [SPB_W-1:0]  samples_per_bar;
  logic [SEC_W-1:0]  section_count;
  logic [WORD_W-1:0] section_words_low;
  logic [WORD_W-1:0] section_words_high;
  logic              loop_enable;

  state_t             state, state_next;
  logic [SPB_W-1:0]   acc, acc_next;
  logic [SEC_W-1:0]   sec, sec_next;
  logic [BIC_W-1:0]   bic, bic_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic               finished, finished_next;
  logic [DIV_W-1:0]   rem, rem_next;
  logic [FORM_W-1:0]  form_len, form_len_next;
  logic [SEC_W-1:0]   fl_idx, fl_idx_next;
  out_item_t          out_next;
  logic               out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SLOT_W-1:0] slots [MAX_SECTIONS];
  logic [SEC_W-1:0]  eff_count;
  logic [SLOT_W-1:0] cur_slot, fl_slot;
  logic              cur_in;
  logic [BARS_W-1:0] cur_bars, fl_bars;
  logic [KIND_W-1:0] cur_kind;
  logic [DIV_W-1:0]  acc_sum;
  logic [BARS_W-1:0] chunk_raw, chunk, bic_sum;
  logic [SEC_W-1:0]  sec_inc;
  logic              do_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bar    <= '0;
      section_count      <= '0;
      section_words_low  <= '0;
      section_words_high <= '0;
      loop_enable        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_BAR:    samples_per_bar    <= cfg_wr_data[SPB_W-1:0];
        REG_SECTION_COUNT:      section_count      <= cfg_wr_data[SEC_W-1:0];
        REG_SECTION_WORDS_LOW:  section_words_low  <= cfg_wr_data[WORD_W-1:0];
        REG_SECTION_WORDS_HIGH: section_words_high <= cfg_wr_data[WORD_W-1:0];
        REG_LOOP_ENABLE:        loop_enable        <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SECTIONS; k++) begin
      if (k < SLOTS_PER_WORD) begin
        slots[k] = section_words_low[k*SLOT_W +: SLOT_W];
      end else begin
        slots[k] = section_words_high[(k-SLOTS_PER_WORD)*SLOT_W +: SLOT_W];
      end
    end
  end

  assign eff_count = (section_count > SEC_W'(MAX_SECTIONS)) ? SEC_W'(MAX_SECTIONS)
                                                           : section_count;

  assign cur_slot = (sec < SEC_W'(MAX_SECTIONS)) ? slots[sec] : '0;
  assign cur_in   = sec < eff_count;
  assign cur_bars = cur_in ? BARS_W'(cur_slot[5:0]) + 1'b1 : BARS_W'(8);
  assign cur_kind = cur_in ? cur_slot[8:6] : '0;

  assign fl_slot = (fl_idx < SEC_W'(MAX_SECTIONS)) ? slots[fl_idx] : '0;
  assign fl_bars = BARS_W'(fl_slot[5:0]) + 1'b1;

  assign acc_sum = DIV_W'(acc) + (DIV_W'(in_data.num_samples) << FRAC_BITS);

  assign chunk_raw = (cur_bars > BARS_W'(bic)) ? cur_bars - BARS_W'(bic) : BARS_W'(1);
  assign chunk     = (rem < DIV_W'(chunk_raw)) ? rem[BARS_W-1:0] : chunk_raw;
  assign bic_sum   = BARS_W'(bic) + chunk;
  assign sec_inc   = sec + 1'b1;
  assign do_skip   = loop_enable && (sec == '0) && (bic == '0) && (rem >= DIV_W'(form_len));

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next       = state;
    acc_next         = acc;
    sec_next         = sec;
    bic_next         = bic;
    total_next       = total;
    finished_next    = finished;
    rem_next         = rem;
    form_len_next    = form_len;
    fl_idx_next      = fl_idx;
    div_req.start    = 1'b0;
    div_req.dividend = acc_sum;
    div_req.divisor  = samples_per_bar;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_RESTART) begin
            acc_next      = '0;
            sec_next      = '0;
            bic_next      = '0;
            total_next    = '0;
            finished_next = 1'b0;
            state_next    = ST_FIN;
          end else if (eff_count == '0 || finished || samples_per_bar == '0) begin
            state_next = ST_FIN;
          end else begin
            div_req.start = 1'b1;
            form_len_next = '0;
            fl_idx_next   = '0;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (fl_idx < eff_count) begin
          form_len_next = form_len + FORM_W'(fl_bars);
          fl_idx_next   = fl_idx + 1'b1;
        end
        if (div_rsp.done) begin
          acc_next   = div_rsp.remainder;
          rem_next   = div_rsp.quotient;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (rem == '0) begin
          state_next = ST_FIN;
        end else if (do_skip) begin
          div_req.start    = 1'b1;
          div_req.dividend = rem;
          div_req.divisor  = SPB_W'(form_len);
          state_next       = ST_SKIP;
        end else begin
          rem_next   = rem - DIV_W'(chunk);
          total_next = total + TOTAL_W'(chunk);
          if (bic_sum >= cur_bars) begin
            bic_next = '0;
            if (sec_inc >= eff_count) begin
              if (loop_enable) begin
                sec_next = '0;
              end else begin
                sec_next      = sec_inc;
                finished_next = 1'b1;
                state_next    = ST_FIN;
              end
            end else begin
              sec_next = sec_inc;
            end
          end else begin
            bic_next = bic_sum[BIC_W-1:0];
          end
        end
      end
      ST_SKIP: begin
        if (div_rsp.done) begin
          total_next = total + TOTAL_W'(rem - DIV_W'(div_rsp.remainder));
          rem_next   = DIV_W'(div_rsp.remainder);
          state_next = ST_STEP;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_next.section_index   = sec;
    out_next.section_kind    = cur_kind;
    out_next.bars_in_section = cur_bars;
    out_next.bars_elapsed    = bic;
    out_next.global_bars     = total;
    out_next.last_bar        = (BARS_W'(bic) + 1'b1) == cur_bars;
    out_next.done_res        = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      sec       <= '0;
      bic       <= '0;
      total     <= '0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      acc      <= acc_next;
      sec      <= sec_next;
      bic      <= bic_next;
      total    <= total_next;
      finished <= finished_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    form_len <= form_len_next;
    fl_idx   <= fl_idx_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  bss_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
